/* hdl/i2c_master_bit_sequencer_assert.svh */
// Assertion macros shared by the I2C master bit sequencer RTL.
`ifndef I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BIT_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define I2CMBS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define I2CMBS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/i2cmbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Item types, sequencer state and command codes.
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

	localparam logic [2:0] MODE_TICK    = 3'd0;
	localparam logic [2:0] MODE_RELEASE = 3'd1;
	localparam logic [2:0] MODE_START   = 3'd2;
	localparam logic [2:0] MODE_STOP    = 3'd3;
	localparam logic [2:0] MODE_WRITE   = 3'd4;
	localparam logic [2:0] MODE_READ    = 3'd5;

	localparam logic LINE_SCL = 1'b0;
	localparam logic LINE_SDA = 1'b1;

	localparam logic [3:0] LAST_BIT = 4'd7;
	localparam logic [3:0] ACK_BIT  = 4'd8;

	typedef struct packed {
		logic [2:0] mode;
		logic       bus_select;
		logic [7:0] tx_byte;
		logic       sda_level;
	} in_item_t;

	typedef struct packed {
		logic       int_scl_low;
		logic       int_sda_low;
		logic       ext_scl_low;
		logic       ext_sda_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_level;
		logic       rejected;
	} out_item_t;

	typedef struct packed {
		logic [3:0] drive_low;
		logic [2:0] command;
		logic       bus;
		logic [7:0] shift;
		logic [3:0] bit_cnt;
		logic [2:0] phase;
		logic       busy;
		logic       ack;
		logic [7:0] rx_last;
	} seq_state_t;

endpackage

/* hdl/i2cmbs_phase.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer phase logic
// Next state and result of one item: command capture and one line phase.
// ----------------------------------------------------------------------------
module i2cmbs_phase (
	input  i2cmbs_pkg::seq_state_t cur,
	input  i2cmbs_pkg::in_item_t   item,
	output i2cmbs_pkg::seq_state_t nxt,
	output i2cmbs_pkg::out_item_t  res
);
	import i2cmbs_pkg::*;

	function automatic logic [3:0] set_line(input logic [3:0] drv, input logic bus,
		input logic line, input logic low);
		logic [3:0] d;
		d = drv;
		d[{bus, line}] = low;
		return d;
	endfunction

	seq_state_t s;
	logic       rej;
	logic       done;

	always_comb begin
		s    = cur;
		rej  = 1'b0;
		done = 1'b0;
		if (item.mode >= MODE_RELEASE && item.mode <= MODE_READ) begin
			if (s.busy) begin
				rej = 1'b1;
			end else begin
				s.command = item.mode;
				s.bus     = item.bus_select;
				s.shift   = (item.mode == MODE_WRITE) ? item.tx_byte : 8'h00;
				s.bit_cnt = 4'd0;
				s.phase   = 3'd0;
				s.busy    = 1'b1;
			end
		end
		if (s.busy) begin
			case (s.command)
				MODE_RELEASE: begin
					if (s.phase == 3'd0) begin
						s.drive_low = set_line(s.drive_low, s.bus, LINE_SCL, 1'b0);
						s.phase     = s.phase + 3'd1;
					end else begin
						s.drive_low = set_line(s.drive_low, s.bus, LINE_SDA, 1'b0);
						done        = 1'b1;
					end
				end
				MODE_START: begin
					if (s.phase == 3'd0) begin
						s.drive_low = set_line(s.drive_low, s.bus, LINE_SCL, 1'b0);
						s.phase     = s.phase + 3'd1;
					end else if (s.phase == 3'd1) begin
						s.drive_low = set_line(s.drive_low, s.bus, LINE_SDA, 1'b1);
						s.phase     = s.phase + 3'd1;
					end else begin
						s.drive_low = set_line(s.drive_low, s.bus, LINE_SCL, 1'b1);
						done        = 1'b1;
					end
				end
				MODE_STOP: begin
					if (s.phase == 3'd0) begin
						s.drive_low = set_line(s.drive_low, s.bus, LINE_SDA, 1'b1);
						s.phase     = s.phase + 3'd1;
					end else if (s.phase == 3'd1) begin
						s.drive_low = set_line(s.drive_low, s.bus, LINE_SCL, 1'b0);
						s.phase     = s.phase + 3'd1;
					end else begin
						s.drive_low = set_line(s.drive_low, s.bus, LINE_SDA, 1'b0);
						done        = 1'b1;
					end
				end
				MODE_WRITE: begin
					if (s.bit_cnt < ACK_BIT) begin
						if (s.phase == 3'd0) begin
							s.drive_low = set_line(s.drive_low, s.bus, LINE_SDA, ~s.shift[7]);
							s.phase     = s.phase + 3'd1;
						end else if (s.phase == 3'd1) begin
							s.drive_low = set_line(s.drive_low, s.bus, LINE_SCL, 1'b0);
							s.phase     = s.phase + 3'd1;
						end else if (s.phase == 3'd2) begin
							s.drive_low = set_line(s.drive_low, s.bus, LINE_SCL, 1'b1);
							s.shift     = {s.shift[6:0], 1'b0};
							if (s.bit_cnt < LAST_BIT) begin
								s.phase   = 3'd0;
								s.bit_cnt = s.bit_cnt + 4'd1;
							end else begin
								s.phase = s.phase + 3'd1;
							end
						end else if (s.phase == 3'd3 && s.bit_cnt == LAST_BIT) begin
							s.drive_low = set_line(s.drive_low, s.bus, LINE_SDA, 1'b0);
							s.phase     = 3'd0;
							s.bit_cnt   = s.bit_cnt + 4'd1;
						end else begin
							done = 1'b1;
						end
					end else if (s.bit_cnt == ACK_BIT) begin
						if (s.phase == 3'd0) begin
							s.drive_low = set_line(s.drive_low, s.bus, LINE_SDA, 1'b0);
							s.phase     = s.phase + 3'd1;
						end else if (s.phase == 3'd1) begin
							s.drive_low = set_line(s.drive_low, s.bus, LINE_SCL, 1'b0);
							s.phase     = s.phase + 3'd1;
						end else begin
							s.ack       = item.sda_level;
							s.drive_low = set_line(s.drive_low, s.bus, LINE_SCL, 1'b1);
							done        = 1'b1;
						end
					end else begin
						done = 1'b1;
					end
				end
				MODE_READ: begin
					if (s.bit_cnt < ACK_BIT) begin
						if (s.phase == 3'd0) begin
							s.drive_low = set_line(s.drive_low, s.bus, LINE_SDA, 1'b0);
							s.phase     = s.phase + 3'd1;
						end else if (s.phase == 3'd1) begin
							s.drive_low = set_line(s.drive_low, s.bus, LINE_SCL, 1'b0);
							s.phase     = s.phase + 3'd1;
						end else begin
							s.shift     = {s.shift[6:0], item.sda_level};
							s.drive_low = set_line(s.drive_low, s.bus, LINE_SCL, 1'b1);
							s.phase     = 3'd0;
							s.bit_cnt   = s.bit_cnt + 4'd1;
						end
					end else if (s.bit_cnt == ACK_BIT) begin
						if (s.phase == 3'd0) begin
							s.drive_low = set_line(s.drive_low, s.bus, LINE_SDA, 1'b1);
							s.phase     = s.phase + 3'd1;
						end else if (s.phase == 3'd1) begin
							s.drive_low = set_line(s.drive_low, s.bus, LINE_SCL, 1'b0);
							s.phase     = s.phase + 3'd1;
						end else begin
							s.drive_low = set_line(s.drive_low, s.bus, LINE_SCL, 1'b1);
							s.rx_last   = s.shift;
							done        = 1'b1;
						end
					end else begin
						done = 1'b1;
					end
				end
				default: begin
					done = 1'b1;
				end
			endcase
			if (done) begin
				s.busy    = 1'b0;
				s.phase   = 3'd0;
				s.bit_cnt = 4'd0;
			end
		end
		nxt             = s;
		res.int_scl_low = s.drive_low[0];
		res.int_sda_low = s.drive_low[1];
		res.ext_scl_low = s.drive_low[2];
		res.ext_sda_low = s.drive_low[3];
		res.busy_res    = s.busy;
		res.done_res    = done;
		res.rx_byte     = s.rx_last;
		res.ack_level   = s.ack;
		res.rejected    = rej;
	end

endmodule

/* hdl/i2c_master_bit_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Open-drain master for an internal and an external bus, one line phase per item.
// ----------------------------------------------------------------------------
// Each accepted item performs at most one line phase and yields one registered
// result item; an item can be accepted every cycle. The sequencer state and
// a single output register form the only storage, so the rate is set by the
// output register: the input stalls only while a result waits to be taken.
module i2c_master_bit_sequencer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  i2cmbs_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output i2cmbs_pkg::out_item_t out_data
);
	import i2cmbs_pkg::*;

	`include "i2c_master_bit_sequencer_assert.svh"

	seq_state_t st_q;
	seq_state_t st_nxt;
	out_item_t  res;
	out_item_t  out_q;
	logic       out_valid_q;
	logic       accept;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	i2cmbs_phase u_phase (
		.cur  (st_q),
		.item (in_data),
		.nxt  (st_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				st_q        <= st_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

	`I2CMBS_ASSERT_NOW(a_done_not_busy, out_valid_q && out_q.done_res, !out_q.busy_res, "done with busy still set")
	`I2CMBS_ASSERT_NEXT(a_reject_when_busy, accept && st_q.busy && in_data.mode >= MODE_RELEASE && in_data.mode <= MODE_READ, out_q.rejected, "busy command not rejected")
	`I2CMBS_ASSERT_NEXT(a_idle_tick_holds, accept && !st_q.busy && in_data.mode == MODE_TICK, $stable(st_q.drive_low) && !out_q.done_res, "idle tick moved the lines")
	`I2CMBS_ASSERT_NOW(a_bit_range, st_q.busy, st_q.bit_cnt <= ACK_BIT, "bit counter past acknowledge slot")

endmodule
